[rtl/m4v4_pkg.sv]
// Shared types and constants for the 4x4 matrix by 4-vector transform.
// No dependencies; imported by m4v4_row and mat4_vec4_transform.
`timescale 1ns / 1ps

package m4v4_pkg;

  localparam int unsigned ElemW    = 32;  // Q16.16 element, vector and result width
  localparam int unsigned NumPairs = 8;
  localparam int unsigned NumDim   = 4;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned PairRegW = 2 * ElemW;
  localparam int unsigned ProdW    = 2 * ElemW;
  localparam int unsigned PsumW    = ProdW + 1;
  localparam int unsigned SumW     = ProdW + 2;
  localparam int unsigned VecW     = NumDim * ElemW;

  typedef logic signed [ElemW-1:0] elem_t;
  typedef logic [PairRegW-1:0]     pair_t;

  // Identity matrix at sixteen fraction bits, kept literal for any FRAC_BITS
  localparam pair_t MatReset [NumPairs] = '{
    64'h0000_0000_0001_0000, 64'h0000_0000_0000_0000,
    64'h0001_0000_0000_0000, 64'h0000_0000_0000_0000,
    64'h0000_0000_0000_0000, 64'h0000_0000_0001_0000,
    64'h0000_0000_0000_0000, 64'h0001_0000_0000_0000
  };

  localparam elem_t SatMax = 32'sh7FFF_FFFF;
  localparam elem_t SatMin = 32'sh8000_0000;

  // Load enables of the four pipeline stages
  typedef struct packed {
    logic s1;  // products
    logic s2;  // pair sums
    logic s3;  // full sum and scale
    logic s4;  // saturate, output register
  } m4v4_en_t;

endpackage

[rtl/m4v4_row.sv]
// One result row: four products, adder tree, floor shift and saturation.
// Depends on m4v4_pkg; stage enables come from the top-level flow control.
`timescale 1ns / 1ps

module m4v4_row import m4v4_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic     clk_i,
  input  m4v4_en_t en_i,
  input  elem_t    elem_i [NumDim],
  input  elem_t    vec_i  [NumDim],
  output elem_t    res_o,
  output logic     clip_o
);

  logic signed [ProdW-1:0] prod_q [NumDim];
  logic signed [PsumW-1:0] psum_a_q, psum_b_q;
  logic signed [SumW-1:0]  sum;
  logic signed [SumW-1:0]  scaled_q;
  logic [SumW-ElemW:0]     upper;
  logic                    in_range;
  elem_t                   res_q;
  logic                    clip_q;

  // Stage 1: one 32x32 signed multiply per column
  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      for (int c = 0; c < NumDim; c++) begin
        prod_q[c] <= ProdW'(elem_i[c]) * ProdW'(vec_i[c]);
      end
    end
  end

  // Stage 2
  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      psum_a_q <= PsumW'(prod_q[0]) + PsumW'(prod_q[1]);
      psum_b_q <= PsumW'(prod_q[2]) + PsumW'(prod_q[3]);
    end
  end

  // Stage 3: exact sum, arithmetic shift floors toward minus infinity
  assign sum = SumW'(psum_a_q) + SumW'(psum_b_q);

  always_ff @(posedge clk_i) begin
    if (en_i.s3) begin
      scaled_q <= sum >>> FRAC_BITS;
    end
  end

  // Stage 4: fits in 32 bits when every bit above bit 30 matches the sign
  assign upper    = scaled_q[SumW-1:ElemW-1];
  assign in_range = (&upper) | ~(|upper);

  always_ff @(posedge clk_i) begin
    if (en_i.s4) begin
      clip_q <= ~in_range;
      if (in_range) begin
        res_q <= scaled_q[ElemW-1:0];
      end else begin
        res_q <= scaled_q[SumW-1] ? SatMin : SatMax;
      end
    end
  end

  assign res_o  = res_q;
  assign clip_o = clip_q;

endmodule

[rtl/mat4_vec4_transform.sv]
// Top level of the 4x4 matrix by 4-vector transform, signed fixed point.
// Depends on m4v4_pkg and m4v4_row (one instance per result row).
//
// Usage:
//   Input stream s_axis_*: one vector (x, y, z, w) per transaction.
//   Output stream m_axis_*: the transformed vector, one transaction for each
//   input; tuser flags that at least one component was clipped.
//   Configuration: cfg_we_i writes cfg_wdata_i into matrix pair cfg_addr_i
//   (two column-major elements, element 2k low, 2k+1 high). Write only while
//   no transaction is in flight.
// Pipeline: four register stages (multiply, pair sums, full sum and scale,
//   saturation); each stage can stall, and the result leaves from the last.
// Throughput: one vector per cycle while m_axis_tready stays high; sixteen
//   multipliers, four per row, all working in the same stage.
// Reset: the pipeline empties and the matrix returns to identity.
// Stall: while m_axis_tready is low the result holds and the stages behind it
//   fill; s_axis_tready drops only when all four stages hold data. Each stage
//   refills in the cycle it empties, so no bubble is left behind.
`timescale 1ns / 1ps

module mat4_vec4_transform import m4v4_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_addr_i,
  input  pair_t              cfg_wdata_i,
  // input stream
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [VecW-1:0]    s_axis_tdata,   // vec_x, vec_y, vec_z, vec_w
  // output stream
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [VecW-1:0]    m_axis_tdata,   // out_x, out_y, out_z, out_w
  output logic               m_axis_tuser    // saturated
);

  localparam int unsigned NumStages = 4;

  pair_t                 mat_q [NumPairs];
  elem_t                 vec [NumDim];
  elem_t                 row_elem [NumDim][NumDim];
  elem_t                 res [NumDim];
  logic [NumDim-1:0]     clip;
  logic [NumStages-1:0]  vld_q;
  logic [NumStages-1:0]  rdy;
  m4v4_en_t              en;

  // Matrix registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NumPairs; k++) begin
        mat_q[k] <= MatReset[k];
      end
    end else if (cfg_we_i) begin
      mat_q[cfg_addr_i] <= cfg_wdata_i;
    end
  end

  // Element c*4+r sits in pair c*2+r/2, upper half when r is odd
  always_comb begin
    for (int r = 0; r < NumDim; r++) begin
      for (int c = 0; c < NumDim; c++) begin
        row_elem[r][c] = (r % 2 == 1) ? mat_q[c*2 + r/2][PairRegW-1:ElemW]
                                      : mat_q[c*2 + r/2][ElemW-1:0];
      end
    end
  end

  always_comb begin
    for (int c = 0; c < NumDim; c++) begin
      vec[c] = s_axis_tdata[c*ElemW +: ElemW];
    end
  end

  // Flow control: a stage loads when empty or when its successor moves on
  always_comb begin
    rdy[NumStages-1] = ~vld_q[NumStages-1] | m_axis_tready;
    for (int k = NumStages - 2; k >= 0; k--) begin
      rdy[k] = ~vld_q[k] | rdy[k+1];
    end
  end

  assign en = '{s1: rdy[0], s2: rdy[1], s3: rdy[2], s4: rdy[3]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[0]) begin
        vld_q[0] <= s_axis_tvalid;
      end
      for (int k = 1; k < NumStages; k++) begin
        if (rdy[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  for (genvar r = 0; r < NumDim; r++) begin : g_row
    m4v4_row #(
      .FRAC_BITS (FRAC_BITS)
    ) u_row (
      .clk_i  (clk_i),
      .en_i   (en),
      .elem_i (row_elem[r]),
      .vec_i  (vec),
      .res_o  (res[r]),
      .clip_o (clip[r])
    );
    assign m_axis_tdata[r*ElemW +: ElemW] = res[r];
  end

  assign s_axis_tready = rdy[0];
  assign m_axis_tvalid = vld_q[NumStages-1];
  assign m_axis_tuser  = |clip;

`ifndef SYNTH
  logic in_acc, out_acc;
  assign in_acc  = s_axis_tvalid & s_axis_tready;
  assign out_acc = m_axis_tvalid & m_axis_tready;

  // Items in flight change only by the transactions on the two sides
  a_occupancy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni) |->
      ($countones(vld_q) + int'($past(out_acc))) ==
      ($past($countones(vld_q)) + int'($past(in_acc))))
    else $error("pipeline occupancy lost or duplicated an item");

  // A stalled result keeps the stage behind it occupied
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[NumStages-1] && vld_q[NumStages-2] && !m_axis_tready) |=>
      (vld_q[NumStages-1] && vld_q[NumStages-2]))
    else $error("stage advanced into a stalled output");

  // The clip flag only comes with a component at a limit
  a_clip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |->
      (res[0] == SatMax || res[0] == SatMin || res[1] == SatMax || res[1] == SatMin ||
       res[2] == SatMax || res[2] == SatMin || res[3] == SatMax || res[3] == SatMin))
    else $error("saturated flag without a clipped component");
`endif

endmodule

[sim/tb_mat4_vec4_transform.sv]
`timescale 1ns / 1ps
// Self-checking testbench for mat4_vec4_transform: streams vectors under several matrices
// and compares each result with a directed table entry or an in-bench fixed-point model.
// Depends on m4v4_pkg and the RTL of mat4_vec4_transform.

module tb_mat4_vec4_transform;
  import m4v4_pkg::*;

  localparam int unsigned FracBits   = 16;
  localparam int unsigned Latency    = 4;
  localparam int unsigned NumRandom  = 850;
  localparam int unsigned NumPhases  = 8;
  localparam int unsigned HoldCycles = 80;
  localparam int unsigned MaxReports = 10;
  localparam int unsigned NumDir     = 18;

  typedef elem_t [NumDim-1:0] vec4_t;  // component 0 (x) in the lowest bits

  typedef struct packed {
    vec4_t comp;
    logic  sat;
  } xform_res_t;

  typedef enum logic [2:0] {
    MkIdent, MkHalf, MkAllMax, MkAllMin, MkMixed, MkFull, MkSmall, MkExtreme
  } mat_kind_e;

  typedef struct packed {
    mat_kind_e  mat;
    vec4_t      vec;
    logic       known;
    xform_res_t res;
  } dir_row_t;

  localparam elem_t Extremes [7] = '{
    SatMax, SatMin, 32'sh0, 32'sh0001_0000, 32'shFFFF_0000, 32'sh1, -32'sh1
  };

  localparam mat_kind_e PhaseKinds [NumPhases] = '{
    MkSmall, MkFull, MkExtreme, MkSmall, MkFull, MkAllMin, MkSmall, MkIdent
  };

  // vec and res read {w, z, y, x}; res only meaningful where known is set
  localparam dir_row_t DirTab [NumDir] = '{
    {MkIdent, 128'h0, 1'b1, 128'h0, 1'b0},
    {MkIdent, {4{32'h7FFF_FFFF}}, 1'b1, {4{32'h7FFF_FFFF}}, 1'b0},
    {MkIdent, {4{32'h8000_0000}}, 1'b1, {4{32'h8000_0000}}, 1'b0},
    {MkIdent, 128'h0001_0000_FFFF_FFFF_8000_0000_7FFF_FFFF, 1'b1,
              128'h0001_0000_FFFF_FFFF_8000_0000_7FFF_FFFF, 1'b0},
    {MkIdent, 128'hAAAA_AAAA_5555_5555_AAAA_AAAA_5555_5555, 1'b1,
              128'hAAAA_AAAA_5555_5555_AAAA_AAAA_5555_5555, 1'b0},
    // half scale: negative odd values floor downwards
    {MkHalf, 128'h0000_0003_FFFF_FFFE_0000_0001_FFFF_FFFF, 1'b1,
             128'h0000_0001_FFFF_FFFF_0000_0000_FFFF_FFFF, 1'b0},
    {MkHalf, {4{32'h8000_0000}}, 1'b1, {4{32'hC000_0000}}, 1'b0},
    {MkHalf, 128'h1234_5678_9ABC_DEF0_0FED_CBA9_8765_4321, 1'b0, 129'h0},
    {MkAllMax, {4{32'h7FFF_FFFF}}, 1'b1, {4{32'h7FFF_FFFF}}, 1'b1},
    {MkAllMax, {4{32'h8000_0000}}, 1'b1, {4{32'h8000_0000}}, 1'b1},
    {MkAllMax, 128'h0, 1'b1, 128'h0, 1'b0},
    {MkAllMax, 128'h0000_0000_0000_0000_0000_0000_0000_0001, 1'b1,
               {4{32'h0000_7FFF}}, 1'b0},
    // largest possible sum, positive
    {MkAllMin, {4{32'h8000_0000}}, 1'b1, {4{32'h7FFF_FFFF}}, 1'b1},
    {MkAllMin, {4{32'h7FFF_FFFF}}, 1'b1, {4{32'h8000_0000}}, 1'b1},
    {MkAllMin, 128'h0000_0000_0000_0000_0000_0000_FFFF_FFFF, 1'b1,
               {4{32'h0000_8000}}, 1'b0},
    {MkMixed, 128'h7FFF_FFFF_8000_0000_0001_0000_FFFF_8000, 1'b0, 129'h0},
    {MkMixed, 128'h0002_0000_FFFE_0000_0000_4000_0003_0000, 1'b0, 129'h0},
    {MkMixed, 128'hC3A5_0F1E_0000_FFFF_7654_3210_FEDC_BA98, 1'b0, 129'h0}
  };

  logic  clk_i;
  logic  rst_ni;
  logic  cfg_we_i;
  logic  [CfgIdxW-1:0] cfg_addr_i;
  pair_t cfg_wdata_i;
  logic  s_axis_tvalid;
  logic  s_axis_tready;
  logic  [VecW-1:0] s_axis_tdata;
  logic  m_axis_tvalid;
  logic  m_axis_tready;
  logic  [VecW-1:0] m_axis_tdata;
  logic  m_axis_tuser;

  pair_t      mat_regs [NumPairs];
  xform_res_t pending_results [$];
  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  int unsigned burst_left = 0;
  bit          hold_req = 1'b0;

  mat4_vec4_transform #(
    .FRAC_BITS(FracBits)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  function automatic elem_t mat_elem(int unsigned e);
    pair_t p;
    p = mat_regs[e / 2];
    return (e % 2) ? $signed(p[2*ElemW-1:ElemW]) : $signed(p[ElemW-1:0]);
  endfunction

  // Row r is the dot product of matrix row r with v, summed exactly, floored, clipped
  function automatic xform_res_t transform_vec(vec4_t v);
    xform_res_t res;
    logic signed [71:0] acc;
    logic signed [71:0] scaled;
    res.sat = 1'b0;
    for (int r = 0; r < NumDim; r++) begin
      acc = '0;
      for (int c = 0; c < NumDim; c++) begin
        acc += mat_elem(c * NumDim + r) * $signed(v[c]);
      end
      scaled = acc >>> FracBits;
      if (scaled > SatMax) begin
        res.comp[r] = SatMax;
        res.sat     = 1'b1;
      end else if (scaled < SatMin) begin
        res.comp[r] = SatMin;
        res.sat     = 1'b1;
      end else begin
        res.comp[r] = scaled[ElemW-1:0];
      end
    end
    return res;
  endfunction

  function automatic elem_t rand_elem(mat_kind_e kind);
    case (kind)
      MkFull:    return $urandom;
      MkSmall:   return $urandom_range(0, 2**19) - 2**18;  // within +-4.0
      MkExtreme: return Extremes[3'($urandom_range(0, 6))];
      default:   return '0;
    endcase
  endfunction

  function automatic pair_t make_pair(mat_kind_e kind, int unsigned idx);
    case (kind)
      MkIdent:  return MatReset[idx];
      MkHalf:   return MatReset[idx] >> 1;
      MkAllMax: return {SatMax, SatMax};
      MkAllMin: return {SatMin, SatMin};
      MkMixed:  return {32'h0001_8000 + 32'(idx) * 32'h0000_3A51,
                        32'hFFFE_4000 - 32'(idx) * 32'h0000_7C13};
      default:  return {rand_elem(kind), rand_elem(kind)};
    endcase
  endfunction

  function automatic elem_t rand_comp();
    case ($urandom_range(0, 3))
      0:       return $urandom;
      1:       return $urandom_range(0, 2**23) - 2**22;
      2:       return Extremes[3'($urandom_range(0, 6))];
      default: return $urandom_range(0, 2**17) - 2**16 + 32'h0001_0000;
    endcase
  endfunction

  function automatic vec4_t rand_vec();
    vec4_t v;
    for (int r = 0; r < NumDim; r++) v[r] = rand_comp();
    return v;
  endfunction

  task automatic log_mismatch(string msg);
    mismatches++;
    if (mismatches <= MaxReports) $display("%0t: %s", $time, msg);
  endtask

  // Only called while the pipeline is empty
  task automatic load_matrix(mat_kind_e kind);
    for (int unsigned i = 0; i < NumPairs; i++) begin
      @(negedge clk_i);
      mat_regs[i] = make_pair(kind, i);
      cfg_we_i    <= 1'b1;
      cfg_addr_i  <= i[CfgIdxW-1:0];
      cfg_wdata_i <= mat_regs[i];
    end
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (Latency + 2) @(posedge clk_i);
  endtask

  // Offers one vector, records its expected result, then idles between bursts
  task automatic send_vec(vec4_t v, logic known, xform_res_t res);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= v;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_results.push_back(known ? res : transform_vec(v));
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      repeat ($urandom_range(1, 12)) begin
        @(negedge clk_i);
        s_axis_tvalid <= 1'b0;
      end
      burst_left = $urandom_range(0, 40);
    end
  endtask

  // Result sink: stall pattern in segments, plus a long hold-off on request
  initial begin : sink
    int unsigned mode;
    int unsigned hold_left;
    bit          hold_taken;
    hold_left  = 0;
    hold_taken = 1'b0;
    m_axis_tready = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      repeat ($urandom_range(5, 60)) begin
        @(negedge clk_i);
        if (hold_req && !hold_taken) begin
          hold_taken = 1'b1;
          hold_left  = HoldCycles;
        end
        if (hold_left > 0) begin
          hold_left--;
          m_axis_tready <= 1'b0;
        end else begin
          case (mode)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= 1'($urandom_range(0, 1));
            2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
            default: m_axis_tready <= ($urandom_range(0, 7) != 0);
          endcase
        end
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    xform_res_t want;
    xform_res_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tdata, m_axis_tuser};
      if (pending_results.size() == 0) begin
        log_mismatch($sformatf("unexpected result %h sat %b", got.comp, got.sat));
      end else begin
        want = pending_results.pop_front();
        for (int r = 0; r < NumDim; r++) begin
          if (got.comp[r] !== want.comp[r]) begin
            log_mismatch($sformatf("result %0d component %0d: expected %h, got %h",
                                   results_seen, r, want.comp[r], got.comp[r]));
          end
        end
        if (got.sat !== want.sat) begin
          log_mismatch($sformatf("result %0d saturated: expected %b, got %b",
                                 results_seen, want.sat, got.sat));
        end
      end
      results_seen++;
    end
  end

  initial begin : stimulus
    mat_kind_e cur_kind;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_addr_i    = '0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    for (int i = 0; i < NumPairs; i++) mat_regs[i] = MatReset[i];
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    cur_kind = MkIdent;
    for (int i = 0; i < NumDir; i++) begin
      if (DirTab[i].mat != cur_kind) begin
        wait_idle();
        load_matrix(DirTab[i].mat);
        cur_kind = DirTab[i].mat;
      end
      send_vec(DirTab[i].vec, DirTab[i].known, DirTab[i].res);
    end

    for (int p = 0; p < NumPhases; p++) begin
      wait_idle();
      load_matrix(PhaseKinds[p]);
      // sink holds off while vectors keep coming, so the pipeline backs up
      if (p == 2) hold_req = 1'b1;
      for (int k = 0; k < NumRandom / NumPhases; k++) begin
        if (p == 4 && k == 50) wait_idle();
        send_vec(rand_vec(), 1'b0, '0);
      end
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/m4v4_pkg.sv
rtl/m4v4_row.sv
rtl/mat4_vec4_transform.sv
sim/tb_mat4_vec4_transform.sv
